>>> src/ter_pkg.sv
package ter_pkg;

  // Field widths of the stream payloads
  localparam int VTX_W      = 16;
  localparam int FRAC_W     = 4;
  localparam int PIXEL_W    = VTX_W - FRAC_W;
  localparam int EDGE_W     = VTX_W + 1;
  localparam int PX_W       = 10;
  localparam int ADDR_W     = 20;
  localparam int COLOR_W    = 32;
  localparam int IN_DATA_W  = 6 * VTX_W;
  localparam int OUT_DATA_W = 2 * PX_W + ADDR_W + COLOR_W;

  localparam logic [COLOR_W-1:0] COLOR_IN  = '1;
  localparam logic [COLOR_W-1:0] COLOR_OUT = 32'hFFFF_0000;

  // Request kind carried in tuser
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [VTX_W-1:0] ax;
    logic signed [VTX_W-1:0] ay;
    logic signed [VTX_W-1:0] bx;
    logic signed [VTX_W-1:0] by;
    logic signed [VTX_W-1:0] cx;
    logic signed [VTX_W-1:0] cy;
  } tri_t;

  // Edge vectors b-a, c-b, a-c
  typedef struct packed {
    logic signed [EDGE_W-1:0] abx;
    logic signed [EDGE_W-1:0] aby;
    logic signed [EDGE_W-1:0] bcx;
    logic signed [EDGE_W-1:0] bcy;
    logic signed [EDGE_W-1:0] cax;
    logic signed [EDGE_W-1:0] cay;
  } edge_t;

endpackage

>>> src/ter_setup.sv
module ter_setup #(
  parameter int SCREEN_W = 1024,
  parameter int SCREEN_H = 1024,
  localparam int XW = $clog2(SCREEN_W),
  localparam int YW = $clog2(SCREEN_H)
) (
  input  ter_pkg::tri_t  vtx,
  output ter_pkg::edge_t edges,
  output logic [XW-1:0]  x_lo,
  output logic [XW-1:0]  x_hi,
  output logic [YW-1:0]  y_lo,
  output logic [YW-1:0]  y_hi,
  output logic           on_screen
);
  import ter_pkg::*;

  localparam int CW = (XW > YW) ? XW : YW;
  localparam int SW = ((PIXEL_W > CW) ? PIXEL_W : CW) + 2;
  localparam logic signed [SW-1:0] X_LIM = SW'(SCREEN_W - 1);
  localparam logic signed [SW-1:0] Y_LIM = SW'(SCREEN_H - 1);

  logic signed [VTX_W-1:0] xmin_v, xmax_v, ymin_v, ymax_v;
  logic signed [SW-1:0]    x0, x1, y0, y1;

  function automatic logic signed [VTX_W-1:0] min3(input logic signed [VTX_W-1:0] p,
                                                   input logic signed [VTX_W-1:0] q,
                                                   input logic signed [VTX_W-1:0] r);
    logic signed [VTX_W-1:0] m;
    m = (p < q) ? p : q;
    return (m < r) ? m : r;
  endfunction

  function automatic logic signed [VTX_W-1:0] max3(input logic signed [VTX_W-1:0] p,
                                                   input logic signed [VTX_W-1:0] q,
                                                   input logic signed [VTX_W-1:0] r);
    logic signed [VTX_W-1:0] m;
    m = (p > q) ? p : q;
    return (m > r) ? m : r;
  endfunction

  function automatic logic signed [SW-1:0] clamp(input logic signed [SW-1:0] v,
                                                 input logic signed [SW-1:0] hi);
    if (v < 0) return '0;
    return (v > hi) ? hi : v;
  endfunction

  // Edge vectors in one extra bit
  always_comb begin
    edges.abx = EDGE_W'(vtx.bx) - EDGE_W'(vtx.ax);
    edges.aby = EDGE_W'(vtx.by) - EDGE_W'(vtx.ay);
    edges.bcx = EDGE_W'(vtx.cx) - EDGE_W'(vtx.bx);
    edges.bcy = EDGE_W'(vtx.cy) - EDGE_W'(vtx.by);
    edges.cax = EDGE_W'(vtx.ax) - EDGE_W'(vtx.cx);
    edges.cay = EDGE_W'(vtx.ay) - EDGE_W'(vtx.cy);
  end

  // Bounding box: floor to whole pixels, then clamp to the screen
  always_comb begin
    xmin_v = min3(vtx.ax, vtx.bx, vtx.cx);
    xmax_v = max3(vtx.ax, vtx.bx, vtx.cx);
    ymin_v = min3(vtx.ay, vtx.by, vtx.cy);
    ymax_v = max3(vtx.ay, vtx.by, vtx.cy);
    x0 = SW'(xmin_v >>> FRAC_W);
    x1 = SW'(xmax_v >>> FRAC_W);
    y0 = SW'(ymin_v >>> FRAC_W);
    y1 = SW'(ymax_v >>> FRAC_W);
    on_screen = !(x1 < 0 || y1 < 0 || x0 > X_LIM || y0 > Y_LIM);
    x_lo = XW'(clamp(x0, X_LIM));
    x_hi = XW'(clamp(x1, X_LIM));
    y_lo = YW'(clamp(y0, Y_LIM));
    y_hi = YW'(clamp(y1, Y_LIM));
  end

endmodule

>>> src/ter_scan.sv
module ter_scan #(
  parameter int SCREEN_W = 1024,
  parameter int SCREEN_H = 1024,
  localparam int XW = $clog2(SCREEN_W),
  localparam int YW = $clog2(SCREEN_H)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           load_en,
  input  logic           step_en,
  input  ter_pkg::tri_t  vtx_in,
  output logic           active,
  output logic [XW-1:0]  scan_x,
  output logic [YW-1:0]  scan_y,
  output logic           scan_last,
  output ter_pkg::tri_t  vtx,
  output ter_pkg::edge_t edges
);
  import ter_pkg::*;

  edge_t         edges_next;
  logic [XW-1:0] x_lo_next, x_hi_next;
  logic [YW-1:0] y_lo_next, y_hi_next;
  logic          on_screen;
  logic [XW-1:0] x_lo, x_hi;
  logic [YW-1:0] y_lo;
  logic          row_end;

  ter_setup #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_setup (
    .vtx       (vtx_in),
    .edges     (edges_next),
    .x_lo      (x_lo_next),
    .x_hi      (x_hi_next),
    .y_lo      (y_lo_next),
    .y_hi      (y_hi_next),
    .on_screen (on_screen)
  );

  assign row_end   = (scan_x >= x_hi);
  assign scan_last = row_end && (scan_y <= y_lo);

  // Load a triangle or advance the scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      vtx    <= '0;
      edges  <= '0;
      x_lo   <= '0;
      x_hi   <= '0;
      y_lo   <= '0;
      scan_x <= '0;
      scan_y <= '0;
    end else if (load_en) begin
      vtx    <= vtx_in;
      edges  <= edges_next;
      active <= on_screen;
      if (on_screen) begin
        x_lo   <= x_lo_next;
        x_hi   <= x_hi_next;
        y_lo   <= y_lo_next;
        scan_x <= x_lo_next;
        scan_y <= y_hi_next;
      end
    end else if (step_en && active) begin
      if (row_end) begin
        scan_x <= x_lo;
        if (scan_last) begin
          active <= 1'b0;
        end else begin
          scan_y <= scan_y - 1'b1;
        end
      end else begin
        scan_x <= scan_x + 1'b1;
      end
    end
  end

endmodule

>>> src/ter_edge.sv
module ter_edge #(
  parameter int SCREEN_W = 1024,
  parameter int SCREEN_H = 1024,
  localparam int XW = $clog2(SCREEN_W),
  localparam int YW = $clog2(SCREEN_H)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              issue,
  input  logic [XW-1:0]                     pos_x,
  input  logic [YW-1:0]                     pos_y,
  input  logic                              pos_last,
  input  ter_pkg::tri_t                     vtx,
  input  ter_pkg::edge_t                    edges,
  output logic                              ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ter_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                              out_last
);
  import ter_pkg::*;

  localparam int CW = (XW > YW) ? XW : YW;
  localparam int DW = ((CW + FRAC_W > VTX_W) ? CW + FRAC_W : VTX_W) + 2;
  localparam int PW = EDGE_W + DW;

  logic signed [EDGE_W-1:0] ex [3];
  logic signed [EDGE_W-1:0] ey [3];
  logic signed [VTX_W-1:0]  vx [3];
  logic signed [VTX_W-1:0]  vy [3];
  logic signed [DW-1:0]     px, py;
  logic signed [DW-1:0]     dx [3];
  logic signed [DW-1:0]     dy [3];
  logic signed [PW-1:0]     prod_a_next [3];
  logic signed [PW-1:0]     prod_b_next [3];

  logic                     s1_valid;
  logic [XW-1:0]            s1_x;
  logic [YW-1:0]            s1_y;
  logic                     s1_last;
  logic [ADDR_W-1:0]        s1_addr;
  logic signed [PW-1:0]     prod_a [3];
  logic signed [PW-1:0]     prod_b [3];

  logic signed [PW:0]       edge_fn [3];
  logic                     in_tri;
  logic                     out_free;
  logic                     s1_move;

  logic [COLOR_W-1:0]       color;
  logic [PX_W-1:0]          pix_x, pix_y;

  // Pixel corner relative to each edge's start vertex
  always_comb begin
    ex[0] = edges.abx; ey[0] = edges.aby; vx[0] = vtx.ax; vy[0] = vtx.ay;
    ex[1] = edges.bcx; ey[1] = edges.bcy; vx[1] = vtx.bx; vy[1] = vtx.by;
    ex[2] = edges.cax; ey[2] = edges.cay; vx[2] = vtx.cx; vy[2] = vtx.cy;
    px = $signed({{(DW - XW - FRAC_W){1'b0}}, pos_x, {FRAC_W{1'b0}}});
    py = $signed({{(DW - YW - FRAC_W){1'b0}}, pos_y, {FRAC_W{1'b0}}});
    for (int k = 0; k < 3; k++) begin
      dx[k] = px - DW'(vx[k]);
      dy[k] = py - DW'(vy[k]);
      prod_a_next[k] = PW'(ex[k]) * PW'(dy[k]);
      prod_b_next[k] = PW'(ey[k]) * PW'(dx[k]);
    end
  end

  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_free;
  assign ready    = !s1_valid || out_free;

  // Product stage: take a new pixel whenever the stage frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && issue) begin
      s1_x    <= pos_x;
      s1_y    <= pos_y;
      s1_last <= pos_last;
      s1_addr <= ADDR_W'(pos_x) + ADDR_W'(ADDR_W'(pos_y) * ADDR_W'(SCREEN_W));
      prod_a  <= prod_a_next;
      prod_b  <= prod_b_next;
    end
  end

  // Sign of each edge function decides the colour
  always_comb begin
    in_tri = 1'b1;
    for (int k = 0; k < 3; k++) begin
      edge_fn[k] = (PW + 1)'(prod_a[k]) - (PW + 1)'(prod_b[k]);
      if (edge_fn[k] < 0) in_tri = 1'b0;
    end
    color = in_tri ? COLOR_IN : COLOR_OUT;
    pix_x = PX_W'(s1_x);
    pix_y = PX_W'(s1_y);
  end

  // Result register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= {color, s1_addr, pix_y, pix_x};
      out_last <= s1_last;
    end
  end

endmodule

>>> src/triangle_edge_rasterizer_top.sv
// Triangle edge-function rasterizer.
//
// Slave stream: tuser selects the request kind (load triangle or next pixel),
// tdata carries the three vertices in signed Q12.4; it is read on a load only.
// Master stream: one pixel per next-pixel request while a scan is running,
// with its column, row, frame-buffer index and colour; tlast marks the last
// pixel of the bounding box. A load emits nothing, nor does a next-pixel
// request when no scan is running.
//
// Throughput: one request per cycle while the receiver keeps up. A pixel
// request passes through a product register and then a result register on
// its way to the master side: the first register holds the three pairs of
// edge products, the second holds the result.
// The scan position advances as each request is accepted, so a load issued
// right behind pixel requests does not disturb those already in flight.
//
// Reset clears the triangle, the box and the scan and leaves the block idle.
// When the receiver stalls the result register holds its pixel, the product
// stage still takes one more request, and s_tready falls only when both
// are full.
module triangle_edge_rasterizer_top #(
  parameter int SCREEN_W = 1024,
  parameter int SCREEN_H = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
  input  logic [ter_pkg::IN_DATA_W-1:0]  s_tdata,
  // opcode
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pixel_x, pixel_y, pixel_address, pixel_color
  output logic [ter_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast
);
  import ter_pkg::*;

  localparam int XW = $clog2(SCREEN_W);
  localparam int YW = $clog2(SCREEN_H);

  tri_t          vtx_in, vtx;
  edge_t         edges;
  logic          accept, load_en, step_en, active, issue;
  logic [XW-1:0] scan_x;
  logic [YW-1:0] scan_y;
  logic          scan_last;

  // Unpack the vertices, first field in the lowest bits
  always_comb begin
    vtx_in.ax = s_tdata[0*VTX_W +: VTX_W];
    vtx_in.ay = s_tdata[1*VTX_W +: VTX_W];
    vtx_in.bx = s_tdata[2*VTX_W +: VTX_W];
    vtx_in.by = s_tdata[3*VTX_W +: VTX_W];
    vtx_in.cx = s_tdata[4*VTX_W +: VTX_W];
    vtx_in.cy = s_tdata[5*VTX_W +: VTX_W];
  end

  assign accept  = s_tvalid && s_tready;
  assign load_en = accept && (op_t'(s_tuser) == OP_LOAD);
  assign step_en = accept && (op_t'(s_tuser) == OP_STEP);
  assign issue   = step_en && active;

  ter_scan #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .load_en   (load_en),
    .step_en   (step_en),
    .vtx_in    (vtx_in),
    .active    (active),
    .scan_x    (scan_x),
    .scan_y    (scan_y),
    .scan_last (scan_last),
    .vtx       (vtx),
    .edges     (edges)
  );

  ter_edge #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_edge (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .pos_x     (scan_x),
    .pos_y     (scan_y),
    .pos_last  (scan_last),
    .vtx       (vtx),
    .edges     (edges),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

>>> src/ter_checker.sv
module ter_checker #(
  parameter int SCREEN_W = 1024
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ter_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import ter_pkg::*;

  logic [PX_W-1:0]    pix_x, pix_y;
  logic [ADDR_W-1:0]  pix_addr, addr_calc;
  logic [COLOR_W-1:0] pix_color;

  assign pix_x     = m_tdata[PX_W-1:0];
  assign pix_y     = m_tdata[2*PX_W-1:PX_W];
  assign pix_addr  = m_tdata[2*PX_W+ADDR_W-1:2*PX_W];
  assign pix_color = m_tdata[OUT_DATA_W-1:2*PX_W+ADDR_W];
  assign addr_calc = ADDR_W'(pix_x) + ADDR_W'(ADDR_W'(pix_y) * ADDR_W'(SCREEN_W));

  // No pixel straight out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("pixel shown right after reset");

  // Stalled pixel holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled pixel changed");

  // Index agrees with the coordinates
  a_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pix_addr == addr_calc)
    else $error("pixel index does not match coordinates");

  // Only the two colours appear
  a_color: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pix_color == COLOR_IN || pix_color == COLOR_OUT))
    else $error("unexpected pixel colour");

endmodule

bind triangle_edge_rasterizer_top ter_checker #(.SCREEN_W(SCREEN_W)) u_ter_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> verif/triangle_edge_rasterizer_top_tb.sv
module triangle_edge_rasterizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ter_pkg::*;

  localparam int SCREEN_W    = 1024;
  localparam int SCREEN_H    = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_TAIL  = 16;

  typedef struct {
    logic [PX_W-1:0]    x;
    logic [PX_W-1:0]    y;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = OP_STEP;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  // Predicted state of the rasterizer
  int   corner [6];
  int   side [6];
  int   col_lo, col_hi, row_lo;
  int   next_col, next_row;
  logic scanning;

  pixel_t expected_pixels [$];
  int     requests_sent  = 0;
  int     mismatch_count = 0;
  int     sender_idle_pct = 0;
  int     stall_pct       = 0;
  int     stall_request   = 0;
  int     hold_left       = 0;

  triangle_edge_rasterizer_top #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Work out the pixel, if any, that an accepted request causes
  function automatic void predict_pixel(input op_t op, input logic [IN_DATA_W-1:0] data);
    int     x0, x1, y0, y1, n;
    longint ex, ey, dx, dy;
    logic   in_tri;
    pixel_t pix;
    if (op == OP_LOAD) begin
      for (int i = 0; i < 6; i++) corner[i] = int'($signed(data[VTX_W*i +: VTX_W]));
      for (int k = 0; k < 3; k++) begin
        n = (k + 1) % 3;
        side[2*k]   = corner[2*n]   - corner[2*k];
        side[2*k+1] = corner[2*n+1] - corner[2*k+1];
      end
      x0 = corner[0]; x1 = corner[0];
      y0 = corner[1]; y1 = corner[1];
      for (int k = 1; k < 3; k++) begin
        if (corner[2*k] < x0) x0 = corner[2*k];
        if (corner[2*k] > x1) x1 = corner[2*k];
        if (corner[2*k+1] < y0) y0 = corner[2*k+1];
        if (corner[2*k+1] > y1) y1 = corner[2*k+1];
      end
      // floor to whole pixels
      x0 = x0 >>> FRAC_W; x1 = x1 >>> FRAC_W;
      y0 = y0 >>> FRAC_W; y1 = y1 >>> FRAC_W;
      if (x1 < 0 || y1 < 0 || x0 > SCREEN_W - 1 || y0 > SCREEN_H - 1) begin
        scanning = 1'b0;
        return;
      end
      col_lo   = (x0 < 0) ? 0 : x0;
      col_hi   = (x1 > SCREEN_W - 1) ? SCREEN_W - 1 : x1;
      row_lo   = (y0 < 0) ? 0 : y0;
      next_col = col_lo;
      next_row = (y1 > SCREEN_H - 1) ? SCREEN_H - 1 : y1;
      scanning = 1'b1;
      return;
    end
    if (!scanning) return;
    // edge functions at the pixel corner, exact in 64 bits
    in_tri = 1'b1;
    for (int k = 0; k < 3; k++) begin
      ex = side[2*k];
      ey = side[2*k+1];
      dx = longint'(next_col * 16) - corner[2*k];
      dy = longint'(next_row * 16) - corner[2*k+1];
      if (ex * dy - ey * dx < 0) in_tri = 1'b0;
    end
    pix.x     = PX_W'(next_col);
    pix.y     = PX_W'(next_row);
    pix.addr  = ADDR_W'(next_col + next_row * SCREEN_W);
    pix.color = in_tri ? COLOR_IN : COLOR_OUT;
    pix.last  = 1'b0;
    // advance the scan: columns up, rows down
    if (next_col >= col_hi) begin
      next_col = col_lo;
      if (next_row <= row_lo) begin
        pix.last = 1'b1;
        scanning = 1'b0;
      end else begin
        next_row = next_row - 1;
      end
    end else begin
      next_col = next_col + 1;
    end
    expected_pixels.push_back(pix);
  endfunction

  // Offer one request, with random gaps, and predict it once taken
  task automatic send_request(input op_t op, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pixel(op, data);
    requests_sent++;
  endtask

  task automatic send_step();
    send_request(OP_STEP, {$urandom, $urandom, $urandom});
  endtask

  task automatic send_load(input int ax, input int ay, input int bx, input int by,
                           input int cx, input int cy);
    send_request(OP_LOAD, {VTX_W'(cy), VTX_W'(cx), VTX_W'(by), VTX_W'(bx),
                           VTX_W'(ay), VTX_W'(ax)});
  endtask

  // Drop valid and hold until every predicted pixel has come back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (stall_request != 0) begin
      hold_left = stall_request;
      stall_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each pixel taken with the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected pixel, expected none actual %0h last %0b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_x", want.x, m_tdata[PX_W-1:0]);
        check_field("pixel_y", want.y, m_tdata[2*PX_W-1:PX_W]);
        check_field("pixel_address", want.addr, m_tdata[2*PX_W+ADDR_W-1:2*PX_W]);
        check_field("pixel_color", want.color, m_tdata[OUT_DATA_W-1:2*PX_W+ADDR_W]);
        check_field("last_pixel", want.last, m_tlast);
      end
    end
  end

  // Give up on a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d pixels outstanding", $time, expected_pixels.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic test_step_while_idle();
    send_step();
    wait_drain();
  endtask

  // Small boxes, both screen corners and a negative fraction
  task automatic test_box_corners();
    send_load(160, 160, 176, 160, 160, 176);
    repeat (5) send_step();
    send_load(-32768, -32768, 31, 0, 0, 15);
    repeat (3) send_step();
    send_load(32767, 32767, 16368, 16368, 32767, 16368);
    send_step();
    wait_drain();
  endtask

  // Boxes wholly left, right, above and below the screen
  task automatic test_offscreen_boxes();
    send_load(-1, 100, -16, 200, -32768, 300);
    send_step();
    send_load(16384, 100, 32767, 200, 20000, 300);
    send_step();
    send_load(100, -1, 200, -5, 300, -100);
    send_step();
    send_load(100, 16384, 200, 32767, 300, 16400);
    send_step();
    wait_drain();
  endtask

  // Abandon a scan part way with a new load
  task automatic test_reload_mid_scan();
    send_load(1600, 1600, 1744, 1600, 1600, 1744);
    repeat (3) send_step();
    send_load(83, 120, 83, 120, 83, 120);
    repeat (2) send_step();
    wait_drain();
  endtask

  // Long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    sender_idle_pct = 0;
    stall_pct       = 0;
    stall_request   = 60;
    send_load(1600, 1600, 1744, 1600, 1600, 1744);
    repeat (30) send_step();
    wait_drain();
  endtask

  // Mostly whole scans of small triangles, with noise and stray steps
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int quota);
    int first, pick, cx, cy, cap, n;
    logic [VTX_W-1:0] v [6];
    sender_idle_pct = sender_pct;
    stall_pct       = receiver_pct;
    first = requests_sent;
    while (requests_sent - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        if ($urandom_range(3) == 0) begin
          cx = $urandom_range(1) ? $urandom_range(0, 7) : $urandom_range(1016, 1023);
          cy = $urandom_range(1) ? $urandom_range(0, 7) : $urandom_range(1016, 1023);
        end else begin
          cx = $urandom_range(0, 1023);
          cy = $urandom_range(0, 1023);
        end
        for (int k = 0; k < 3; k++) begin
          v[2*k]   = VTX_W'(cx * 16 + int'($urandom_range(128)) - 64);
          v[2*k+1] = VTX_W'(cy * 16 + int'($urandom_range(128)) - 64);
        end
        send_request(OP_LOAD, {v[5], v[4], v[3], v[2], v[1], v[0]});
        cap = ($urandom_range(4) == 0) ? $urandom_range(1, 20) : 200;
        n = 0;
        while (scanning && n < cap) begin
          send_step();
          n++;
        end
        repeat ($urandom_range(2)) send_step();
      end else if (pick < 90) begin
        send_request(OP_LOAD, {$urandom, $urandom, $urandom});
        repeat ($urandom_range(6)) send_step();
      end else begin
        send_step();
      end
    end
    wait_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_step_while_idle();
    test_box_corners();
    test_offscreen_boxes();
    test_reload_mid_scan();
    test_backpressure();
    test_random_traffic(0, 0, 500);
    test_random_traffic(67, 0, 500);
    test_random_traffic(0, 67, 500);
    test_random_traffic(30, 30, 500);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
